### hw/rtl/ctcs_pkg.sv
// Shared constants, codes and types for the corner touch calibration solver.
// No dependencies; every other file of the block but ctcs_ram imports this package.
package ctcs_pkg;

  // Raw sample resolution as held in the corner store.
  localparam int unsigned RawBits       = 12;
  localparam int unsigned SumBits       = RawBits + 2;
  localparam int unsigned CornerBits    = 2 * RawBits;
  localparam int unsigned NumCorners    = 4;
  localparam int unsigned CornerIdxBits = 2;
  localparam int unsigned SpanCmpBits   = (RawBits > 12) ? RawBits : 12;

  // Configuration port.
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 12;

  localparam logic [CfgIdxBits-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_TARGET_INSET  = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_MIN_SPAN      = 3'd3;

  localparam logic [11:0] ScreenWidthRst  = 12'd320;
  localparam logic [11:0] ScreenHeightRst = 12'd240;
  localparam logic [10:0] TargetInsetRst  = 11'd20;
  localparam logic [11:0] MinSpanRst      = 12'd100;

  // Input commands.
  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [2:0] COUNT_FULL = 3'd4;

  // floor(v / 3) for any 12-bit v is (v * 2731) >> 13.
  localparam logic [11:0]  RECIP3      = 12'd2731;
  localparam int unsigned  Recip3Shift = 13;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_INSET,
    ST_TARGET,
    ST_LOAD,
    ST_FOLD,
    ST_SOLVE,
    ST_CHECK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                     en;
    logic                     first;
    logic [CornerIdxBits-1:0] idx;
  } fold_ctrl_t;

  // Edge deltas are two's complement.
  typedef struct packed {
    logic [SumBits-1:0] dx_x;
    logic [SumBits-1:0] dx_y;
    logic [SumBits-1:0] dy_x;
    logic [SumBits-1:0] dy_y;
    logic [RawBits-1:0] x_min;
    logic [RawBits-1:0] x_max;
    logic [RawBits-1:0] y_min;
    logic [RawBits-1:0] y_max;
  } fold_res_t;

  typedef struct packed {
    logic [2:0]  samples_held;
    logic        complete;
    logic        cal_valid;
    logic [11:0] span_x_low;
    logic [11:0] span_x_high;
    logic [11:0] span_y_low;
    logic [11:0] span_y_high;
    logic        swap_axes;
    logic        flip_x;
    logic        flip_y;
    logic [10:0] target_x;
    logic [10:0] target_y;
  } result_t;

endpackage

### hw/rtl/ctcs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ctcs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/ctcs_fold.sv
// Corner fold unit: folds one stored corner per cycle into the edge sums and
// the per-axis minimum and maximum. Depends on ctcs_pkg.
module ctcs_fold (
  input  logic                                clk_i,
  input  ctcs_pkg::fold_ctrl_t                ctrl_i,
  input  logic [ctcs_pkg::CornerBits-1:0]     corner_i,
  output ctcs_pkg::fold_res_t                 res_o
);
  import ctcs_pkg::*;

  logic [RawBits-1:0] x_val;
  logic [RawBits-1:0] y_val;
  logic [SumBits-1:0] x_ext;
  logic [SumBits-1:0] y_ext;
  fold_res_t          base;
  fold_res_t          acc_d;
  fold_res_t          acc_q;

  function automatic logic [SumBits-1:0] acc_step(logic [SumBits-1:0] a,
                                                  logic [SumBits-1:0] v,
                                                  logic               add);
    acc_step = add ? (a + v) : (a - v);
  endfunction

  always_comb begin
    x_val = corner_i[RawBits-1:0];
    y_val = corner_i[CornerBits-1:RawBits];
    x_ext = SumBits'(x_val);
    y_ext = SumBits'(y_val);
    base  = ctrl_i.first ? '0 : acc_q;
    acc_d = acc_q;
    if (ctrl_i.en) begin
      // Right-hand corners add to the X-edge delta, bottom corners to the Y-edge delta.
      acc_d.dx_x = acc_step(base.dx_x, x_ext, ctrl_i.idx[0]);
      acc_d.dx_y = acc_step(base.dx_y, y_ext, ctrl_i.idx[0]);
      acc_d.dy_x = acc_step(base.dy_x, x_ext, ctrl_i.idx[1]);
      acc_d.dy_y = acc_step(base.dy_y, y_ext, ctrl_i.idx[1]);
      if (ctrl_i.first) begin
        acc_d.x_min = x_val;
        acc_d.x_max = x_val;
        acc_d.y_min = y_val;
        acc_d.y_max = y_val;
      end else begin
        acc_d.x_min = (x_val < acc_q.x_min) ? x_val : acc_q.x_min;
        acc_d.x_max = (x_val > acc_q.x_max) ? x_val : acc_q.x_max;
        acc_d.y_min = (y_val < acc_q.y_min) ? y_val : acc_q.y_min;
        acc_d.y_max = (y_val > acc_q.y_max) ? y_val : acc_q.y_max;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign res_o = acc_q;

endmodule

### hw/rtl/corner_touch_calibration_solver.sv
// Top level of the corner touch calibration solver: sequencer, configuration
// registers, corner store, fold unit and output register. Depends on ctcs_pkg.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+------------------------------------
//   cfg      | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//   in       | in        | in_valid_i / in_ready_o | cmd_i, raw_x_i, raw_y_i
//   out      | out       | out_valid_o/out_ready_i | samples_held_o ... target_y_o
//
// An item that leaves fewer than four corners held passes from acceptance to the
// next acceptance through one reciprocal multiply for the inset limit, the clamp,
// the target and the hand-over to the output register.
// An item that leaves four corners held also passes through the fold unit, which
// takes one corner a cycle from the corner store's single read port.
// Reset restores the register defaults and clears the corner count; the corner
// store itself is not cleared. The sequencer stalls only while the previous word
// still sits unread in the output register.
module corner_touch_calibration_solver (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ctcs_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [ctcs_pkg::CfgDataBits-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic [11:0]                         raw_x_i,
  input  logic [11:0]                         raw_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [2:0]                          samples_held_o,
  output logic                                complete_o,
  output logic                                cal_valid_o,
  output logic [11:0]                         span_x_low_o,
  output logic [11:0]                         span_x_high_o,
  output logic [11:0]                         span_y_low_o,
  output logic [11:0]                         span_y_high_o,
  output logic                                swap_axes_o,
  output logic                                flip_x_o,
  output logic                                flip_y_o,
  output logic [10:0]                         target_x_o,
  output logic [10:0]                         target_y_o
);
  import ctcs_pkg::*;

  state_e      state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [CornerIdxBits-1:0] idx_q, idx_d;
  logic        out_valid_q, out_valid_d;

  logic [11:0] width_q, height_q, min_span_q;
  logic [10:0] inset_q;

  logic [23:0] prod_q, prod_d;
  logic [10:0] ins_q, ins_d;
  logic [10:0] quot;
  logic [11:0] min_side;
  logic [RawBits-1:0] xlo_q, xlo_d, xhi_q, xhi_d, ylo_q, ylo_d, yhi_q, yhi_d;
  logic        swap_q, swap_d, flip_x_q, flip_x_d, flip_y_q, flip_y_d;
  logic [SumBits-1:0] abs_dxx, abs_dxy;
  logic        swap_c;
  logic        span_x_ok, span_y_ok;
  result_t     res_q, res_d, out_q, out_d;

  logic                     ram_we;
  logic [CornerIdxBits-1:0] ram_waddr, ram_raddr;
  logic [CornerBits-1:0]    ram_wdata, ram_rdata;

  fold_ctrl_t fold_ctrl;
  fold_res_t  fold_res;

  // Target for the right column or bottom row, saturated to the 11-bit range.
  function automatic logic [10:0] far_target(logic [11:0] size, logic [10:0] ins);
    logic [12:0] t;
    t = {1'b0, size} - 13'd1 - {2'b00, ins};
    if (t[12]) begin
      far_target = 11'd0;
    end else if (t[11]) begin
      far_target = 11'h7FF;
    end else begin
      far_target = t[10:0];
    end
  endfunction

  ctcs_ram #(
    .Width (CornerBits),
    .Depth (NumCorners)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ctcs_fold u_fold (
    .clk_i    (clk_i),
    .ctrl_i   (fold_ctrl),
    .corner_i (ram_rdata),
    .res_o    (fold_res)
  );

  assign ram_waddr = cnt_q[CornerIdxBits-1:0];
  assign ram_wdata = {RawBits'(raw_y_i), RawBits'(raw_x_i)};

  assign min_side = (width_q < height_q) ? width_q : height_q;
  assign quot     = prod_q[Recip3Shift +: 11];
  assign abs_dxx  = fold_res.dx_x[SumBits-1] ? (~fold_res.dx_x + SumBits'(1)) : fold_res.dx_x;
  assign abs_dxy  = fold_res.dx_y[SumBits-1] ? (~fold_res.dx_y + SumBits'(1)) : fold_res.dx_y;
  assign swap_c   = abs_dxy > abs_dxx;
  assign span_x_ok = SpanCmpBits'(xhi_q - xlo_q) >= SpanCmpBits'(min_span_q);
  assign span_y_ok = SpanCmpBits'(yhi_q - ylo_q) >= SpanCmpBits'(min_span_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    prod_d      = prod_q;
    ins_d       = ins_q;
    xlo_d       = xlo_q;
    xhi_d       = xhi_q;
    ylo_d       = ylo_q;
    yhi_d       = yhi_q;
    swap_d      = swap_q;
    flip_x_d    = flip_x_q;
    flip_y_d    = flip_y_q;
    res_d       = res_q;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = idx_q;
    fold_ctrl   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          idx_d = '0;
          if (cmd_i == CMD_RESTART) begin
            cnt_d = '0;
          end else if (cnt_q < COUNT_FULL) begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + 3'd1;
          end
          state_d = (cnt_d == COUNT_FULL) ? ST_LOAD : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        prod_d  = 24'(min_side) * 24'(RECIP3);
        state_d = ST_INSET;
      end
      ST_INSET: begin
        ins_d   = (quot < inset_q) ? quot : inset_q;
        state_d = ST_TARGET;
      end
      ST_TARGET: begin
        res_d              = '0;
        res_d.samples_held = cnt_q;
        res_d.target_x     = cnt_q[0] ? far_target(width_q, ins_q) : ins_q;
        res_d.target_y     = cnt_q[1] ? far_target(height_q, ins_q) : ins_q;
        state_d            = ST_DONE;
      end
      ST_LOAD: begin
        ram_raddr = '0;
        state_d   = ST_FOLD;
      end
      ST_FOLD: begin
        fold_ctrl.en    = 1'b1;
        fold_ctrl.first = (idx_q == '0);
        fold_ctrl.idx   = idx_q;
        ram_raddr       = idx_q + CornerIdxBits'(1);
        idx_d           = idx_q + CornerIdxBits'(1);
        if (idx_q == CornerIdxBits'(NumCorners - 1)) begin
          state_d = ST_SOLVE;
        end
      end
      ST_SOLVE: begin
        swap_d   = swap_c;
        xlo_d    = swap_c ? fold_res.y_min : fold_res.x_min;
        xhi_d    = swap_c ? fold_res.y_max : fold_res.x_max;
        ylo_d    = swap_c ? fold_res.x_min : fold_res.y_min;
        yhi_d    = swap_c ? fold_res.x_max : fold_res.y_max;
        flip_x_d = swap_c ? fold_res.dx_y[SumBits-1] : fold_res.dx_x[SumBits-1];
        flip_y_d = swap_c ? fold_res.dy_x[SumBits-1] : fold_res.dy_y[SumBits-1];
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        res_d              = '0;
        res_d.samples_held = cnt_q;
        res_d.complete     = 1'b1;
        res_d.cal_valid    = span_x_ok && span_y_ok;
        res_d.span_x_low   = 12'(xlo_q);
        res_d.span_x_high  = 12'(xhi_q);
        res_d.span_y_low   = 12'(ylo_q);
        res_d.span_y_high  = 12'(yhi_q);
        res_d.swap_axes    = swap_q;
        res_d.flip_x       = flip_x_q;
        res_d.flip_y       = flip_y_q;
        state_d            = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= ScreenWidthRst;
      height_q   <= ScreenHeightRst;
      inset_q    <= TargetInsetRst;
      min_span_q <= MinSpanRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SCREEN_WIDTH:  width_q    <= cfg_data_i;
        REG_SCREEN_HEIGHT: height_q   <= cfg_data_i;
        REG_TARGET_INSET:  inset_q    <= cfg_data_i[10:0];
        REG_MIN_SPAN:      min_span_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    ins_q    <= ins_d;
    xlo_q    <= xlo_d;
    xhi_q    <= xhi_d;
    ylo_q    <= ylo_d;
    yhi_q    <= yhi_d;
    swap_q   <= swap_d;
    flip_x_q <= flip_x_d;
    flip_y_q <= flip_y_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign samples_held_o = out_q.samples_held;
  assign complete_o     = out_q.complete;
  assign cal_valid_o    = out_q.cal_valid;
  assign span_x_low_o   = out_q.span_x_low;
  assign span_x_high_o  = out_q.span_x_high;
  assign span_y_low_o   = out_q.span_y_low;
  assign span_y_high_o  = out_q.span_y_high;
  assign swap_axes_o    = out_q.swap_axes;
  assign flip_x_o       = out_q.flip_x;
  assign flip_y_o       = out_q.flip_y;
  assign target_x_o     = out_q.target_x;
  assign target_y_o     = out_q.target_y;

endmodule

### hw/rtl/ctcs_checker.sv
// Port-level checks on the corner touch calibration solver, and the bind that
// attaches them to the top level. Depends on ctcs_pkg for port widths.
module ctcs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cfg_we_i,
  input logic [ctcs_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input logic [ctcs_pkg::CfgDataBits-1:0] cfg_data_i,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             cmd_i,
  input logic [11:0]                      raw_x_i,
  input logic [11:0]                      raw_y_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [2:0]                       samples_held_o,
  input logic                             complete_o,
  input logic                             cal_valid_o,
  input logic [11:0]                      span_x_low_o,
  input logic [11:0]                      span_x_high_o,
  input logic [11:0]                      span_y_low_o,
  input logic [11:0]                      span_y_high_o,
  input logic                             swap_axes_o,
  input logic                             flip_x_o,
  input logic                             flip_y_o,
  input logic [10:0]                      target_x_o,
  input logic [10:0]                      target_y_o
);
  import ctcs_pkg::*;

  // A word that is not taken stays offered, with its count, X target and low X span unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(samples_held_o)
      && $stable(target_x_o) && $stable(span_x_low_o))
    else $error("output word dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (complete_o == (samples_held_o == COUNT_FULL)))
    else $error("complete flag disagrees with the corner count");

  // Before all corners are in, the solution fields read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !complete_o |-> !cal_valid_o && !swap_axes_o && !flip_x_o && !flip_y_o
      && span_x_low_o == 12'd0 && span_x_high_o == 12'd0
      && span_y_low_o == 12'd0 && span_y_high_o == 12'd0)
    else $error("solution fields set before calibration is complete");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && complete_o |-> target_x_o == 11'd0 && target_y_o == 11'd0
      && span_x_low_o <= span_x_high_o && span_y_low_o <= span_y_high_o)
    else $error("complete word has a target or an inverted span");

endmodule

bind corner_touch_calibration_solver ctcs_checker u_ctcs_checker (.*);

### tb/tb_corner_touch_calibration_solver.sv
// Self-checking testbench for the corner touch calibration solver: a scoreboard class
// predicts every result word from the accepted input words and checks them in order.
// Depends on ctcs_pkg and corner_touch_calibration_solver.
`timescale 1ns / 1ps

module tb_corner_touch_calibration_solver;
  import ctcs_pkg::*;

  localparam logic [CfgIdxBits-1:0] REG_UNMAPPED = 3'd6;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned PhaseItems   = 228;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned StuckLimit   = 3000;

  class calib_scoreboard;
    int width_px, height_px, inset_px, span_min;
    int corner_x[4], corner_y[4];
    int held;
    result_t expected_calibrations[$];
    int unsigned errors;

    function new();
      width_px  = ScreenWidthRst;
      height_px = ScreenHeightRst;
      inset_px  = TargetInsetRst;
      span_min  = MinSpanRst;
      held      = 0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
      case (idx)
        REG_SCREEN_WIDTH:  width_px  = data;
        REG_SCREEN_HEIGHT: height_px = data;
        REG_TARGET_INSET:  inset_px  = data[10:0];
        REG_MIN_SPAN:      span_min  = data;
        default: ;
      endcase
    endfunction

    // Works out the result word caused by one accepted input word.
    function void note_touch_item(logic cmd, logic [11:0] x, logic [11:0] y);
      result_t r;
      int d_xx, d_xy, d_yx, d_yy, xd, yd, lim, ins, tx, ty, i;
      int xs[4], ys[4];
      int xlo, xhi, ylo, yhi;
      bit swap;
      if (cmd == CMD_RESTART) begin
        held = 0;
      end else if (held < 4) begin
        corner_x[held] = x;
        corner_y[held] = y;
        held++;
      end
      r = '0;
      r.samples_held = 3'(held);
      r.complete     = (held == 4);
      if (r.complete) begin
        d_xx = (corner_x[1] + corner_x[3]) - (corner_x[0] + corner_x[2]);
        d_xy = (corner_y[1] + corner_y[3]) - (corner_y[0] + corner_y[2]);
        d_yx = (corner_x[2] + corner_x[3]) - (corner_x[0] + corner_x[1]);
        d_yy = (corner_y[2] + corner_y[3]) - (corner_y[0] + corner_y[1]);
        // A tie in magnitude keeps the axes as they are.
        swap = ((d_xy < 0) ? -d_xy : d_xy) > ((d_xx < 0) ? -d_xx : d_xx);
        for (i = 0; i < 4; i++) begin
          xs[i] = swap ? corner_y[i] : corner_x[i];
          ys[i] = swap ? corner_x[i] : corner_y[i];
        end
        xd  = swap ? d_xy : d_xx;
        yd  = swap ? d_yx : d_yy;
        xlo = xs[0]; xhi = xs[0]; ylo = ys[0]; yhi = ys[0];
        for (i = 1; i < 4; i++) begin
          if (xs[i] < xlo) xlo = xs[i];
          if (xs[i] > xhi) xhi = xs[i];
          if (ys[i] < ylo) ylo = ys[i];
          if (ys[i] > yhi) yhi = ys[i];
        end
        r.cal_valid   = ((xhi - xlo) >= span_min) && ((yhi - ylo) >= span_min);
        r.span_x_low  = 12'(xlo);
        r.span_x_high = 12'(xhi);
        r.span_y_low  = 12'(ylo);
        r.span_y_high = 12'(yhi);
        r.swap_axes   = swap;
        r.flip_x      = (xd < 0);
        r.flip_y      = (yd < 0);
      end else begin
        lim = ((width_px < height_px) ? width_px : height_px) / 3;
        ins = (inset_px > lim) ? lim : inset_px;
        tx  = (held == 1 || held == 3) ? width_px - 1 - ins : ins;
        ty  = (held == 2 || held == 3) ? height_px - 1 - ins : ins;
        tx  = (tx < 0) ? 0 : ((tx > 2047) ? 2047 : tx);
        ty  = (ty < 0) ? 0 : ((ty > 2047) ? 2047 : ty);
        r.target_x = 11'(tx);
        r.target_y = 11'(ty);
      end
      expected_calibrations = {expected_calibrations, r};
    endfunction

    function void check_field(string name, logic [11:0] want, logic [11:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_calibrations.size() == 0) begin
        $error("result word arrived with no expectation waiting");
        errors++;
        return;
      end
      want = expected_calibrations.pop_front();
      check_field("samples_held", want.samples_held, got.samples_held);
      check_field("complete", want.complete, got.complete);
      check_field("cal_valid", want.cal_valid, got.cal_valid);
      check_field("span_x_low", want.span_x_low, got.span_x_low);
      check_field("span_x_high", want.span_x_high, got.span_x_high);
      check_field("span_y_low", want.span_y_low, got.span_y_low);
      check_field("span_y_high", want.span_y_high, got.span_y_high);
      check_field("swap_axes", want.swap_axes, got.swap_axes);
      check_field("flip_x", want.flip_x, got.flip_x);
      check_field("flip_y", want.flip_y, got.flip_y);
      check_field("target_x", want.target_x, got.target_x);
      check_field("target_y", want.target_y, got.target_y);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic cmd_i = CMD_SAMPLE;
  logic [11:0] raw_x_i = '0;
  logic [11:0] raw_y_i = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o;
  logic [2:0] samples_held_o;
  logic complete_o, cal_valid_o, swap_axes_o, flip_x_o, flip_y_o;
  logic [11:0] span_x_low_o, span_x_high_o, span_y_low_o, span_y_high_o;
  logic [10:0] target_x_o, target_y_o;
  result_t seen_word;

  calib_scoreboard sb;
  int unsigned snd_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit hold_request = 1'b0;
  bit hold_served = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stuck_cycles = 0;

  corner_touch_calibration_solver u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .raw_x_i       (raw_x_i),
    .raw_y_i       (raw_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .samples_held_o(samples_held_o),
    .complete_o    (complete_o),
    .cal_valid_o   (cal_valid_o),
    .span_x_low_o  (span_x_low_o),
    .span_x_high_o (span_x_high_o),
    .span_y_low_o  (span_y_low_o),
    .span_y_high_o (span_y_high_o),
    .swap_axes_o   (swap_axes_o),
    .flip_x_o      (flip_x_o),
    .flip_y_o      (flip_y_o),
    .target_x_o    (target_x_o),
    .target_y_o    (target_y_o)
  );

  assign seen_word = {samples_held_o, complete_o, cal_valid_o, span_x_low_o, span_x_high_o,
                      span_y_low_o, span_y_high_o, swap_axes_o, flip_x_o, flip_y_o,
                      target_x_o, target_y_o};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: random stalls, and once a long hold-off so that the block backs up.
  always @(posedge clk_i) begin
    if (hold_request && !hold_served) begin
      hold_served = 1'b1;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(seen_word);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= StuckLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offers one word and returns at the edge where it is accepted. The valid stays high
  // on return so that a following word can be offered without a gap.
  task automatic send_item(logic cmd, logic [11:0] x, logic [11:0] y);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    raw_x_i    <= x;
    raw_y_i    <= y;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_touch_item(cmd, x, y);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_calibrations.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  function automatic int draw_span();
    return ($urandom_range(3) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 4095);
  endfunction

  function automatic logic [11:0] jiggle(int v, int jit);
    int t;
    t = v + int'($urandom_range(0, 2 * jit)) - jit;
    return 12'((t < 0) ? 0 : ((t > 4095) ? 4095 : t));
  endfunction

  // Mostly complete four-corner sequences of random geometry, with some noise between.
  task automatic run_random(int unsigned n_items);
    int unsigned sent, k, n_extra;
    int lo_a, lo_b, sp_a, sp_b, jit, va, vb;
    bit swap_g, flip_a, flip_b;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        sp_a   = draw_span();
        sp_b   = draw_span();
        lo_a   = $urandom_range(0, 4095 - sp_a);
        lo_b   = $urandom_range(0, 4095 - sp_b);
        jit    = ($urandom_range(3) == 0) ? $urandom_range(0, 60) : 0;
        swap_g = 1'($urandom_range(1));
        flip_a = 1'($urandom_range(1));
        flip_b = 1'($urandom_range(1));
        send_item(CMD_RESTART, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
        for (k = 0; k < 4; k++) begin
          va = ((k[0] != 0) ^ flip_a) ? lo_a + sp_a : lo_a;
          vb = ((k[1] != 0) ^ flip_b) ? lo_b + sp_b : lo_b;
          if (swap_g) send_item(CMD_SAMPLE, jiggle(vb, jit), jiggle(va, jit));
          else        send_item(CMD_SAMPLE, jiggle(va, jit), jiggle(vb, jit));
        end
        n_extra = $urandom_range(0, 2);
        repeat (n_extra) begin
          send_item(CMD_SAMPLE, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
        end
        sent += 5 + n_extra;
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(($urandom_range(99) < 20) ? CMD_RESTART : CMD_SAMPLE,
                    12'($urandom_range(4095)), 12'($urandom_range(4095)));
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int unsigned ph;
    int w, h, ins, ms;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset settings, no idling.
    send_item(CMD_RESTART, 12'hFFF, 12'hFFF);
    send_item(CMD_SAMPLE, 12'd0, 12'd0);
    send_item(CMD_SAMPLE, 12'hFFF, 12'd0);
    send_item(CMD_SAMPLE, 12'd0, 12'hFFF);
    send_item(CMD_SAMPLE, 12'hFFF, 12'hFFF);
    send_item(CMD_SAMPLE, 12'hFFF, 12'hFFF);  // a fifth sample must be ignored
    send_item(CMD_RESTART, 12'd0, 12'd0);
    // Screen X follows raw Y.
    send_item(CMD_SAMPLE, 12'd100, 12'd100);
    send_item(CMD_SAMPLE, 12'd100, 12'd3000);
    send_item(CMD_SAMPLE, 12'd3000, 12'd100);
    send_item(CMD_SAMPLE, 12'd3000, 12'd3000);
    send_item(CMD_RESTART, 12'hAAA, 12'h555);
    // Both axes inverted.
    send_item(CMD_SAMPLE, 12'd4000, 12'd4000);
    send_item(CMD_SAMPLE, 12'd50, 12'd4000);
    send_item(CMD_SAMPLE, 12'd4000, 12'd50);
    send_item(CMD_SAMPLE, 12'd50, 12'd50);
    send_item(CMD_RESTART, 12'h555, 12'hAAA);
    // Equal edge magnitudes on both raw axes: no swap.
    send_item(CMD_SAMPLE, 12'd0, 12'd0);
    send_item(CMD_SAMPLE, 12'd1000, 12'd1000);
    send_item(CMD_SAMPLE, 12'd0, 12'd0);
    send_item(CMD_SAMPLE, 12'd1000, 12'd1000);
    send_item(CMD_RESTART, 12'd0, 12'd0);
    send_item(CMD_SAMPLE, 12'd1234, 12'd2345);
    send_item(CMD_SAMPLE, 12'd3456, 12'd789);
    send_item(CMD_RESTART, 12'd0, 12'd0);

    for (ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      case (ph)
        0: begin w = 2048; h = 2048; ins = 2047; ms = 0; end
        1: begin w = 1; h = 1; ins = 0; ms = 4095; end
        2: begin w = 4095; h = 4095; ins = 0; ms = 1; end
        3: begin w = 0; h = 240; ins = 4095; ms = 100; end
        4: begin w = ScreenWidthRst; h = ScreenHeightRst; ins = TargetInsetRst; ms = MinSpanRst; end
        default: begin
          w   = $urandom_range(1, 2048);
          h   = $urandom_range(1, 2048);
          ins = $urandom_range(0, 4095);
          ms  = $urandom_range(0, 1500);
        end
      endcase
      write_cfg(REG_SCREEN_WIDTH, 12'(w));
      write_cfg(REG_SCREEN_HEIGHT, 12'(h));
      write_cfg(REG_TARGET_INSET, 12'(ins));
      write_cfg(REG_MIN_SPAN, 12'(ms));
      write_cfg(REG_UNMAPPED, 12'($urandom_range(4095)));
      cfg_we_i <= 1'b0;
      case (ph % 4)
        0: begin snd_idle_pct = 0;  stall_pct = 0;  end
        1: begin snd_idle_pct = 47; stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  stall_pct = 47; end
        default: begin snd_idle_pct = 14; stall_pct = 14; end
      endcase
      if (ph == 4) hold_request = 1'b1;
      run_random(PhaseItems);
    end

    wait_idle();
    if (sb.errors == 0 && sb.expected_calibrations.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/ctcs_pkg.sv
hw/rtl/ctcs_ram.sv
hw/rtl/ctcs_fold.sv
hw/rtl/corner_touch_calibration_solver.sv
hw/rtl/ctcs_checker.sv
tb/tb_corner_touch_calibration_solver.sv
